@@ rtl/srgh_pkg.sv @@
// Shared types and constants for the symbol repeat-gap histogram unit.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package srgh_pkg;

    // Request kinds carried on s_tuser.
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Fixed field widths of the stream interface.
    localparam int SYMBOL_W    = 8;
    localparam int BIN_INDEX_W = 8;
    localparam int BIN_COUNT_W = 32;

    // Output queue sizing; the depth must stay a power of two.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    // Control bits handed from the history stage to the histogram stage.
    typedef struct packed {
        logic vld;
        logic is_read;
        logic seen;
    } s1_ctrl_t;

    // One result item as it sits in the output queue.
    typedef struct packed {
        logic [BIN_INDEX_W-1:0] read_bin;
        logic [BIN_COUNT_W-1:0] bin_count;
    } out_item_t;

endpackage

@@ rtl/srgh_history.sv @@
// First stage: last-seen position memory, seen flags and the stream position.
// Depends on srgh_pkg.
module srgh_history #(
    parameter int SYMBOL_BITS   = 8,
    parameter int POSITION_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_acc,
    input  logic                                in_mode,
    input  logic [srgh_pkg::SYMBOL_W-1:0]       in_symbol,
    input  logic [srgh_pkg::BIN_INDEX_W-1:0]    in_bin_index,
    output srgh_pkg::s1_ctrl_t                  s1_ctrl,
    output logic [srgh_pkg::BIN_INDEX_W-1:0]    s1_bin_index,
    output logic [POSITION_BITS-1:0]            s1_pos,
    output logic [POSITION_BITS-1:0]            s1_last
);

    localparam int NUM_SYMBOLS = 1 << SYMBOL_BITS;

    logic [POSITION_BITS-1:0]             last_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0]               seen_reg;
    logic [POSITION_BITS-1:0]             pos_reg;
    logic [POSITION_BITS-1:0]             last_rd_reg;
    logic [POSITION_BITS-1:0]             pos1_reg;
    logic [srgh_pkg::BIN_INDEX_W-1:0]     bin1_reg;
    srgh_pkg::s1_ctrl_t                   ctrl_reg;
    srgh_pkg::s1_ctrl_t                   ctrl_next;
    logic [15:0]                          sym_wide;
    logic [SYMBOL_BITS-1:0]               sym_addr;
    logic                                 push;

    assign sym_wide = 16'(in_symbol);
    assign sym_addr = sym_wide[SYMBOL_BITS-1:0];
    assign push     = in_acc && (in_mode == srgh_pkg::MODE_PUSH);

    always_comb begin
        ctrl_next.vld     = in_acc;
        ctrl_next.is_read = (in_mode == srgh_pkg::MODE_READ);
        ctrl_next.seen    = seen_reg[sym_addr];
    end

    // The read returns the old entry; a write made here is seen by the next request.
    always_ff @(posedge aclk) begin
        if (push) begin
            last_rd_reg         <= last_mem[sym_addr];
            last_mem[sym_addr]  <= pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            pos1_reg <= pos_reg;
            bin1_reg <= in_bin_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            pos_reg  <= '0;
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= ctrl_next;
            if (push) begin
                seen_reg[sym_addr] <= 1'b1;
                pos_reg            <= pos_reg + POSITION_BITS'(1);
            end
        end
    end

    assign s1_ctrl      = ctrl_reg;
    assign s1_bin_index = bin1_reg;
    assign s1_pos       = pos1_reg;
    assign s1_last      = last_rd_reg;

endmodule

@@ rtl/srgh_hist.sv @@
// Second and third stages: gap computation, histogram memory read, saturating
// increment with write-back and forwarding. Depends on srgh_pkg.
module srgh_hist #(
    parameter int MAX_GAP       = 128,
    parameter int COUNT_BITS    = 32,
    parameter int POSITION_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  srgh_pkg::s1_ctrl_t                  s1_ctrl,
    input  logic [srgh_pkg::BIN_INDEX_W-1:0]    s1_bin_index,
    input  logic [POSITION_BITS-1:0]            s1_pos,
    input  logic [POSITION_BITS-1:0]            s1_last,
    output logic                                out_vld,
    output srgh_pkg::out_item_t                 out_item
);

    localparam int NUM_BINS = MAX_GAP + 1;
    localparam int BIN_W    = $clog2(NUM_BINS);
    localparam int GAP_W    = (POSITION_BITS > BIN_W) ? POSITION_BITS : BIN_W;
    localparam int IDX_W    = (BIN_W > srgh_pkg::BIN_INDEX_W) ? BIN_W : srgh_pkg::BIN_INDEX_W;

    logic [COUNT_BITS-1:0]              cnt_mem [NUM_BINS];
    logic [NUM_BINS-1:0]                bin_vld_reg;

    logic [POSITION_BITS-1:0]           gap;
    logic [GAP_W-1:0]                   gap_ext;
    logic [IDX_W-1:0]                   idx_ext;
    logic                               gap_ok;
    logic                               idx_ok;
    logic                               rd_en;
    logic                               inc1;
    logic [BIN_W-1:0]                   addr1;

    logic                               rd2_reg;
    logic                               inc2_reg;
    logic                               hit2_reg;
    logic                               fwd2_reg;
    logic                               vb2_reg;
    logic [BIN_W-1:0]                   addr2_reg;
    logic [srgh_pkg::BIN_INDEX_W-1:0]   bin2_reg;
    logic [COUNT_BITS-1:0]              rdata_reg;
    logic [COUNT_BITS-1:0]              fwd_data_reg;
    logic                               fwd_next;

    logic [COUNT_BITS-1:0]              cur_cnt;
    logic [COUNT_BITS-1:0]              new_cnt;
    logic [COUNT_BITS-1:0]              shown_cnt;

    // Items strictly between the two occurrences, modulo the position width.
    assign gap     = s1_pos - s1_last - POSITION_BITS'(1);
    assign gap_ext = GAP_W'(gap);
    assign gap_ok  = gap_ext <= GAP_W'(MAX_GAP);
    assign idx_ext = IDX_W'(s1_bin_index);
    assign idx_ok  = idx_ext <= IDX_W'(MAX_GAP);

    assign addr1 = s1_ctrl.is_read ? idx_ext[BIN_W-1:0] : gap_ext[BIN_W-1:0];
    assign inc1  = s1_ctrl.vld && !s1_ctrl.is_read && s1_ctrl.seen && gap_ok;
    assign rd_en = inc1 || (s1_ctrl.vld && s1_ctrl.is_read && idx_ok);

    // A bin written back at this edge is not yet in the memory read data.
    assign fwd_next = inc2_reg && rd_en && (addr1 == addr2_reg);

    always_comb begin
        if (fwd2_reg) begin
            cur_cnt = fwd_data_reg;
        end else if (vb2_reg) begin
            cur_cnt = rdata_reg;
        end else begin
            cur_cnt = '0;
        end
        new_cnt   = (&cur_cnt) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
        shown_cnt = hit2_reg ? cur_cnt : '0;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg    <= cnt_mem[addr1];
            fwd_data_reg <= new_cnt;
        end
        if (inc2_reg) begin
            cnt_mem[addr2_reg] <= new_cnt;
        end
        addr2_reg <= addr1;
        bin2_reg  <= s1_bin_index;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_vld_reg <= '0;
            rd2_reg     <= 1'b0;
            inc2_reg    <= 1'b0;
            hit2_reg    <= 1'b0;
            fwd2_reg    <= 1'b0;
            vb2_reg     <= 1'b0;
        end else begin
            rd2_reg  <= s1_ctrl.vld && s1_ctrl.is_read;
            inc2_reg <= inc1;
            hit2_reg <= idx_ok;
            fwd2_reg <= fwd_next;
            vb2_reg  <= bin_vld_reg[addr1];
            if (inc2_reg) begin
                bin_vld_reg[addr2_reg] <= 1'b1;
            end
        end
    end

    assign out_vld            = rd2_reg;
    assign out_item.read_bin  = bin2_reg;
    assign out_item.bin_count = srgh_pkg::BIN_COUNT_W'(shown_cnt);

    a_wb_marks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        inc2_reg |=> bin_vld_reg[$past(addr2_reg)])
        else $error("histogram write-back did not mark its bin valid");

    a_push_read_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(inc2_reg && rd2_reg))
        else $error("increment and read request in the same stage");

    a_fwd_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd2_reg |-> $past(inc2_reg))
        else $error("forwarding flagged without a write-back");

endmodule

@@ rtl/srgh_outq.sv @@
// Small result queue that decouples the histogram pipeline from m_tready.
// Depends on srgh_pkg.
module srgh_outq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  srgh_pkg::out_item_t                 push_item,
    input  logic                                pop_rdy,
    output logic                                out_vld,
    output srgh_pkg::out_item_t                 out_item,
    output logic [srgh_pkg::OUTQ_CNT_W-1:0]     level
);

    srgh_pkg::out_item_t                 q_mem [srgh_pkg::OUTQ_DEPTH];
    logic [srgh_pkg::OUTQ_PTR_W-1:0]     wr_ptr_reg;
    logic [srgh_pkg::OUTQ_PTR_W-1:0]     rd_ptr_reg;
    logic [srgh_pkg::OUTQ_CNT_W-1:0]     cnt_reg;
    logic [srgh_pkg::OUTQ_CNT_W-1:0]     cnt_next;
    logic                                pop;

    assign pop = (cnt_reg != '0) && pop_rdy;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + srgh_pkg::OUTQ_CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - srgh_pkg::OUTQ_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + srgh_pkg::OUTQ_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + srgh_pkg::OUTQ_PTR_W'(1);
            end
        end
    end

    assign out_vld  = (cnt_reg != '0);
    assign out_item = q_mem[rd_ptr_reg];
    assign level    = cnt_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && !pop && (cnt_reg == srgh_pkg::OUTQ_CNT_W'(srgh_pkg::OUTQ_DEPTH))))
        else $error("result queue overflow");

endmodule

@@ rtl/symbol_repeat_gap_histogram_unit.sv @@
// Path: a read request is registered in u_history, u_hist and the queue before m_tvalid.
// Throughput: one request per cycle, push or read, while s_tready is high. The
// histogram bin is read in one stage and written back in the next with forwarding
// (one read and one write port).
// Reset: aresetn clears the seen flags, histogram valid bits, stream position and
// queue; no clearing pass is needed and s_tready is high right after.
// Depends on srgh_pkg, srgh_history, srgh_hist and srgh_outq.
module symbol_repeat_gap_histogram_unit #(
    parameter int MAX_GAP       = 128,
    parameter int SYMBOL_BITS   = 8,
    parameter int COUNT_BITS    = 32,
    parameter int POSITION_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request side.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] symbol, [15:8] bin_index
    input  logic        s_tuser,    // [0] mode: 0 pushes a symbol, 1 reads a bin
    // Result side.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [31:0] bin_count, [39:32] read_bin
);

    // The request is taken whenever the queue has room for every read request
    // that is already in flight, so backpressure on m_tready never reaches
    // the input combinationally and the pipeline itself never stalls.

    localparam int RSV_W = srgh_pkg::OUTQ_CNT_W + 1;

    srgh_pkg::s1_ctrl_t                 s1_ctrl;
    logic [srgh_pkg::BIN_INDEX_W-1:0]   s1_bin_index;
    logic [POSITION_BITS-1:0]           s1_pos;
    logic [POSITION_BITS-1:0]           s1_last;
    logic                               res_vld;
    srgh_pkg::out_item_t                res_item;
    srgh_pkg::out_item_t                q_item;
    logic [srgh_pkg::OUTQ_CNT_W-1:0]    q_level;
    logic [RSV_W-1:0]                   reserved;
    logic                               s_acc;

    assign s_acc = s_tvalid && s_tready;

    // Queue slots already promised: stored results plus read requests in
    // the two pipeline stages.
    assign reserved = RSV_W'(q_level)
                    + RSV_W'(s1_ctrl.vld && s1_ctrl.is_read)
                    + RSV_W'(res_vld);
    assign s_tready = reserved < RSV_W'(srgh_pkg::OUTQ_DEPTH);

    // Stage one: look up where the symbol was last seen and record the new
    // position in the same cycle.
    srgh_history #(
        .SYMBOL_BITS   (SYMBOL_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_history (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_acc       (s_acc),
        .in_mode      (s_tuser),
        .in_symbol    (s_tdata[7:0]),
        .in_bin_index (s_tdata[15:8]),
        .s1_ctrl      (s1_ctrl),
        .s1_bin_index (s1_bin_index),
        .s1_pos       (s1_pos),
        .s1_last      (s1_last)
    );

    // Stages two and three: form the gap, read the bin, and either bump it
    // with saturation or present it as a result.
    srgh_hist #(
        .MAX_GAP       (MAX_GAP),
        .COUNT_BITS    (COUNT_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_hist (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s1_ctrl      (s1_ctrl),
        .s1_bin_index (s1_bin_index),
        .s1_pos       (s1_pos),
        .s1_last      (s1_last),
        .out_vld      (res_vld),
        .out_item     (res_item)
    );

    // Results wait here until the downstream side takes them.
    srgh_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_vld),
        .push_item (res_item),
        .pop_rdy   (m_tready),
        .out_vld   (m_tvalid),
        .out_item  (q_item),
        .level     (q_level)
    );

    assign m_tdata = {q_item.read_bin, q_item.bin_count};

    // The reservation scheme must never promise more slots than exist.
    a_reserve_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        reserved <= RSV_W'(srgh_pkg::OUTQ_DEPTH))
        else $error("more results in flight than queue slots");

endmodule
